// ===== rtl/sws_pkg.sv =====
`default_nettype none

package sws_pkg;

    // Input opcodes
    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_ACK  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_EOS  = 2'd3;

    // Result kinds
    localparam logic [2:0] KIND_HEADER    = 3'd0;
    localparam logic [2:0] KIND_PAYLOAD   = 3'd1;
    localparam logic [2:0] KIND_DELIVERED = 3'd2;
    localparam logic [2:0] KIND_GAVE_UP   = 3'd3;
    localparam logic [2:0] KIND_REJECTED  = 3'd4;

    // Configuration register indexes
    localparam logic REG_TIMEOUT  = 1'b0;
    localparam logic REG_ATTEMPTS = 1'b1;

    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;
    localparam logic [2:0]  ATTEMPTS_RESET = 3'd3;

    // Decoded item; flag is last_byte for bytes and ack_seq for acknowledgements
    typedef struct packed {
        logic [1:0] op;
        logic [7:0] data;
        logic       flag;
    } cmd_t;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [2:0]  max_attempts;
    } cfg_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       seq_bit;
        logic [4:0] frame_length;
        logic [7:0] frame_checksum;
        logic [7:0] payload_out;
        logic [2:0] attempt_number;
        logic       run_end;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/sws_if.sv =====
`default_nettype none

interface sws_item_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       ack_seq;

    modport source (output valid, opcode, data_byte, last_byte, ack_seq, input ready);
    modport sink   (input valid, opcode, data_byte, last_byte, ack_seq, output ready);
endinterface

interface sws_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic       seq_bit;
    logic [4:0] frame_length;
    logic [7:0] frame_checksum;
    logic [7:0] payload_out;
    logic [2:0] attempt_number;
    logic       run_end;

    modport source (output valid, kind, seq_bit, frame_length, frame_checksum,
                    payload_out, attempt_number, run_end, input ready);
    modport sink   (input valid, kind, seq_bit, frame_length, frame_checksum,
                    payload_out, attempt_number, run_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/sws_front.sv =====
`default_nettype none

module sws_front
    import sws_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    sws_item_if.sink    items,
    output logic        cmd_valid,
    output cmd_t        cmd,
    input  wire logic   cmd_ready
);

    logic front_valid_reg;
    cmd_t front_cmd_reg;
    cmd_t decoded;
    logic accept;

    // Take a new item whenever the stage is empty or drains this cycle
    assign items.ready = !front_valid_reg || cmd_ready;
    assign accept      = items.valid && items.ready;

    always_comb
    begin
        decoded.op   = items.opcode;
        decoded.data = items.data_byte;
        case (items.opcode)
            OP_BYTE: decoded.flag = items.last_byte;
            OP_ACK:  decoded.flag = items.ack_seq;
            default: decoded.flag = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            front_valid_reg <= 1'b1;
        end
        else if (cmd_ready)
        begin
            front_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_cmd_reg <= decoded;
        end
    end

    assign cmd_valid = front_valid_reg;
    assign cmd       = front_cmd_reg;

endmodule

`default_nettype wire

// ===== rtl/sws_queue.sv =====
`default_nettype none

module sws_queue
    import sws_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push_valid,
    input  wire cmd_t   push_cmd,
    output logic        push_ready,
    output logic        pop_valid,
    output cmd_t        pop_cmd,
    input  wire logic   pop_ready
);

    localparam int DEPTH = 2;

    cmd_t       entry_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'(DEPTH));
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sws_back.sv =====
`default_nettype none

module sws_back
    import sws_pkg::*;
#(
    parameter int MAX_PAYLOAD = 16
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cfg_t   cfg,
    input  wire logic   cmd_valid,
    input  wire cmd_t   cmd,
    output logic        cmd_ready,
    sws_result_if.source results
);

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CW = $clog2(MAX_PAYLOAD + 1);
    localparam logic [CW-1:0] FILL_MAX = CW'(MAX_PAYLOAD);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HDR  = 2'd1;
    localparam logic [1:0] ST_DAT  = 2'd2;

    logic [1:0]    state_reg,    state_next;
    logic          send_seq_reg, send_seq_next;
    logic          awaiting_reg, awaiting_next;
    logic [2:0]    fail_reg,     fail_next;
    logic [15:0]   tick_reg,     tick_next;
    logic [CW-1:0] fill_reg,     fill_next;
    logic [7:0]    xor_reg,      xor_next;
    logic          final_reg,    final_next;
    logic [CW-1:0] idx_reg,      idx_next;
    logic          res_valid_reg, res_valid_next;
    result_t       res_reg,      res_next;

    logic [7:0]    store [MAX_PAYLOAD];
    logic [7:0]    rd_data_reg;
    logic          store_we;

    logic          out_free;
    logic          frame_seq;
    logic [7:0]    checksum;
    logic [15:0]   tmo_limit;
    logic [2:0]    att_limit;
    logic [15:0]   tick_inc;
    logic [2:0]    fail_inc;
    logic [CW-1:0] fill_plus;
    logic [CW-1:0] idx_plus;
    result_t       resolve_res;
    logic [2:0]    resolve_kind;
    logic [2:0]    resolve_att;
    logic          do_resolve;

    assign out_free  = !res_valid_reg || results.ready;
    assign frame_seq = final_reg ? 1'b0 : send_seq_reg;
    assign checksum  = {7'd0, frame_seq} ^ 8'(fill_reg) ^ xor_reg;
    assign tmo_limit = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;
    assign att_limit = (cfg.max_attempts == 3'd0) ? 3'd1 : cfg.max_attempts;
    assign tick_inc  = (tick_reg != 16'hFFFF) ? tick_reg + 16'd1 : tick_reg;
    assign fail_inc  = (fail_reg != 3'd7) ? fail_reg + 3'd1 : fail_reg;
    assign fill_plus = fill_reg + CW'(1);
    assign idx_plus  = idx_reg + CW'(1);

    always_comb
    begin
        resolve_res.kind           = resolve_kind;
        resolve_res.seq_bit        = frame_seq;
        resolve_res.frame_length   = 5'(fill_reg);
        resolve_res.frame_checksum = checksum;
        resolve_res.payload_out    = 8'd0;
        resolve_res.attempt_number = resolve_att;
        resolve_res.run_end        = 1'b1;
    end

    always_comb
    begin
        state_next     = state_reg;
        send_seq_next  = send_seq_reg;
        awaiting_next  = awaiting_reg;
        fail_next      = fail_reg;
        tick_next      = tick_reg;
        fill_next      = fill_reg;
        xor_next       = xor_reg;
        final_next     = final_reg;
        idx_next       = idx_reg;
        res_valid_next = res_valid_reg && !results.ready;
        res_next       = res_reg;
        cmd_ready      = 1'b0;
        store_we       = 1'b0;
        do_resolve     = 1'b0;
        resolve_kind   = KIND_DELIVERED;
        resolve_att    = fail_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_ready = 1'b1;
                    case (cmd.op)
                        OP_BYTE:
                        begin
                            if (awaiting_reg || fill_reg >= FILL_MAX)
                            begin
                                res_valid_next = 1'b1;
                                res_next       = '0;
                                res_next.kind    = KIND_REJECTED;
                                res_next.run_end = 1'b1;
                            end
                            else
                            begin
                                store_we  = 1'b1;
                                fill_next = fill_plus;
                                xor_next  = xor_reg ^ cmd.data;
                                if (cmd.flag || fill_plus >= FILL_MAX)
                                begin
                                    final_next    = 1'b0;
                                    awaiting_next = 1'b1;
                                    fail_next     = 3'd0;
                                    tick_next     = 16'd0;
                                    idx_next      = '0;
                                    state_next    = ST_HDR;
                                end
                            end
                        end
                        OP_EOS:
                        begin
                            if (awaiting_reg || fill_reg != '0)
                            begin
                                res_valid_next = 1'b1;
                                res_next       = '0;
                                res_next.kind    = KIND_REJECTED;
                                res_next.run_end = 1'b1;
                            end
                            else
                            begin
                                final_next    = 1'b1;
                                xor_next      = 8'd0;
                                awaiting_next = 1'b1;
                                fail_next     = 3'd0;
                                tick_next     = 16'd0;
                                idx_next      = '0;
                                state_next    = ST_HDR;
                            end
                        end
                        OP_ACK:
                        begin
                            if (awaiting_reg)
                            begin
                                if (cmd.flag == frame_seq)
                                begin
                                    do_resolve = 1'b1;
                                end
                                else
                                begin
                                    fail_next = fail_inc;
                                    tick_next = 16'd0;
                                    if (fail_inc >= att_limit)
                                    begin
                                        do_resolve   = 1'b1;
                                        resolve_kind = KIND_GAVE_UP;
                                        resolve_att  = fail_inc;
                                    end
                                    else
                                    begin
                                        idx_next   = '0;
                                        state_next = ST_HDR;
                                    end
                                end
                            end
                        end
                        OP_TICK:
                        begin
                            if (awaiting_reg)
                            begin
                                tick_next = tick_inc;
                                if (tick_inc >= tmo_limit)
                                begin
                                    fail_next = fail_inc;
                                    tick_next = 16'd0;
                                    if (fail_inc >= att_limit)
                                    begin
                                        do_resolve   = 1'b1;
                                        resolve_kind = KIND_GAVE_UP;
                                        resolve_att  = fail_inc;
                                    end
                                    else
                                    begin
                                        idx_next   = '0;
                                        state_next = ST_HDR;
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            cmd_ready = 1'b1;
                        end
                    endcase

                    if (do_resolve)
                    begin
                        res_valid_next = 1'b1;
                        res_next       = resolve_res;
                        send_seq_next  = final_reg ? 1'b0 : ~send_seq_reg;
                        awaiting_next  = 1'b0;
                        fail_next      = 3'd0;
                        tick_next      = 16'd0;
                        fill_next      = '0;
                        xor_next       = 8'd0;
                        final_next     = 1'b0;
                    end
                end
            end
            ST_HDR:
            begin
                if (out_free)
                begin
                    res_valid_next         = 1'b1;
                    res_next.kind           = KIND_HEADER;
                    res_next.seq_bit        = frame_seq;
                    res_next.frame_length   = 5'(fill_reg);
                    res_next.frame_checksum = checksum;
                    res_next.payload_out    = 8'd0;
                    res_next.attempt_number = fail_reg;
                    res_next.run_end        = (fill_reg == '0);
                    state_next = (fill_reg == '0) ? ST_IDLE : ST_DAT;
                end
            end
            ST_DAT:
            begin
                // rd_data_reg already holds the byte at idx_reg
                if (out_free)
                begin
                    res_valid_next         = 1'b1;
                    res_next.kind           = KIND_PAYLOAD;
                    res_next.seq_bit        = frame_seq;
                    res_next.frame_length   = 5'(fill_reg);
                    res_next.frame_checksum = checksum;
                    res_next.payload_out    = rd_data_reg;
                    res_next.attempt_number = fail_reg;
                    res_next.run_end        = (idx_plus == fill_reg);
                    idx_next = idx_plus;
                    if (idx_plus == fill_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            send_seq_reg  <= 1'b0;
            awaiting_reg  <= 1'b0;
            fail_reg      <= 3'd0;
            tick_reg      <= 16'd0;
            fill_reg      <= '0;
            xor_reg       <= 8'd0;
            final_reg     <= 1'b0;
            idx_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            send_seq_reg  <= send_seq_next;
            awaiting_reg  <= awaiting_next;
            fail_reg      <= fail_next;
            tick_reg      <= tick_next;
            fill_reg      <= fill_next;
            xor_reg       <= xor_next;
            final_reg     <= final_next;
            idx_reg       <= idx_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    // Payload store: write at the fill position, read one byte ahead of the sender
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store[fill_reg[AW-1:0]] <= cmd.data;
        end
        rd_data_reg <= store[idx_next[AW-1:0]];
    end

    assign results.valid          = res_valid_reg;
    assign results.kind           = res_reg.kind;
    assign results.seq_bit        = res_reg.seq_bit;
    assign results.frame_length   = res_reg.frame_length;
    assign results.frame_checksum = res_reg.frame_checksum;
    assign results.payload_out    = res_reg.payload_out;
    assign results.attempt_number = res_reg.attempt_number;
    assign results.run_end        = res_reg.run_end;

    a_send_needs_outstanding: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> awaiting_reg)
        else $error("frame being sent without an outstanding frame");

    a_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DAT) |-> (idx_reg < fill_reg))
        else $error("payload index past frame length");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_MAX)
        else $error("fill count beyond buffer size");

    a_header_outstanding: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.kind == KIND_HEADER) |-> awaiting_reg)
        else $error("header waiting while no frame outstanding");

    a_resolve_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_next && !(res_valid_reg && !results.ready)
            && (res_next.kind == KIND_DELIVERED || res_next.kind == KIND_GAVE_UP))
        |=> (!awaiting_reg && fill_reg == '0))
        else $error("frame resolved but state not cleared");

endmodule

`default_nettype wire

// ===== rtl/stop_and_wait_sender_unit.sv =====
// Channel   | Role  | Payload
// ----------+-------+------------------------------------------------------------
// items     | sink  | opcode, data_byte, last_byte, ack_seq
// results   | source| kind, seq_bit, frame_length, frame_checksum, payload_out,
//           |       | attempt_number, run_end
// cfg       | write | cfg_we, cfg_index (0 timeout_ticks, 1 max_attempts), cfg_wdata
//
// The sender takes bytes, ticks and acknowledgements only while idle. Items flow in
// at one per cycle, unless held by a stall, through a registered decode stage and a
// two-entry command queue. For a frame the sender acts on the item, then gives one
// result per cycle unless stalled (header, then bytes) from the payload store one ahead.
// Reset clears all control state at once; the payload store is not cleared.
// A stalled result register holds the sender; the queue keeps taking items until full.
`default_nettype none

module stop_and_wait_sender_unit
    import sws_pkg::*;
#(
    parameter int MAX_PAYLOAD = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    sws_item_if.sink                   items,
    sws_result_if.source               results,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    cfg_t cfg_reg;
    logic front_valid;
    cmd_t front_cmd;
    logic front_ready;
    logic queue_valid;
    cmd_t queue_cmd;
    logic queue_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ticks <= TIMEOUT_RESET;
            cfg_reg.max_attempts  <= ATTEMPTS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TIMEOUT:  cfg_reg.timeout_ticks <= cfg_wdata;
                REG_ATTEMPTS: cfg_reg.max_attempts  <= cfg_wdata[2:0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    sws_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (items),
        .cmd_valid (front_valid),
        .cmd       (front_cmd),
        .cmd_ready (front_ready)
    );

    sws_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_cmd   (front_cmd),
        .push_ready (front_ready),
        .pop_valid  (queue_valid),
        .pop_cmd    (queue_cmd),
        .pop_ready  (queue_ready)
    );

    sws_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (queue_valid),
        .cmd       (queue_cmd),
        .cmd_ready (queue_ready),
        .results   (results)
    );

endmodule

`default_nettype wire
